// ----- rtl/exact_price_order_book_matcher_unit_macros.svh -----
// assertion helpers for the order book matcher checker
`ifndef EXACT_PRICE_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define EXACT_PRICE_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define EPOBM_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("epobm check failed");

// condition must never be seen outside reset
`define EPOBM_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error("epobm check failed");

`endif

// ----- rtl/epobm_pkg.sv -----
// ----------------------------------------------------------------------------
// epobm_pkg
// shared constants, codes and controller/datapath types of the order book matcher
// ----------------------------------------------------------------------------
package epobm_pkg;

	localparam int LEVELS_PER_SIDE  = 64;
	localparam int SLOT_W           = $clog2(LEVELS_PER_SIDE);
	localparam int LVL_W            = SLOT_W + 1;
	localparam int NUM_LEVELS       = 2 * LEVELS_PER_SIDE;
	localparam int ORDERS_PER_LEVEL = 16;
	localparam int POS_W            = 4;
	localparam int CNT_W            = 5;
	localparam int ORD_ADDR_W       = LVL_W + POS_W;
	localparam int PRICE_BITS       = 24;
	localparam int PRICE_W          = 24;
	localparam int QTY_W            = 16;
	localparam int IDENT_W          = 32;
	localparam int TOT_W            = 21;
	localparam int AFTER_W          = 20;
	localparam int REMOVED_W        = 5;
	localparam int OUTCOME_W        = 3;

	localparam logic BUY  = 1'b0;
	localparam logic SELL = 1'b1;

	typedef enum logic [OUTCOME_W-1:0] {
		OC_NEW     = 3'd0,
		OC_JOINED  = 3'd1,
		OC_CLEAR   = 3'd2,
		OC_PARTIAL = 3'd3,
		OC_SWEPT   = 3'd4,
		OC_REJECT  = 3'd5
	} outcome_t;

	typedef enum logic [2:0] {
		DEC_CLEAR,
		DEC_WALK,
		DEC_SWEEP,
		DEC_REST,
		DEC_REJECT
	} decision_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_WALK_RD,
		ST_WALK_EX,
		ST_WALK_END
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic walk_rd;
		logic walk_ex;
		logic walk_end;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic need_walk;
		logic walk_go;
	} dp_stat_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [TOT_W-1:0]   total;
		logic [POS_W-1:0]   head;
		logic [CNT_W-1:0]   count;
	} lvl_word_t;

	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		logic [QTY_W-1:0]   qty;
	} ord_word_t;

endpackage

// ----- rtl/epobm_ctrl.sv -----
// ----------------------------------------------------------------------------
// epobm_ctrl
// sequencer: level scan, decision, fifo walk over the matched level
// ----------------------------------------------------------------------------
module epobm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  epobm_pkg::dp_stat_t stat,
	output epobm_pkg::ctl_cmd_t cmd,
	output logic                busy
);
	import epobm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = stat.need_walk ? ST_WALK_RD : ST_IDLE;
			end
			ST_WALK_RD: begin
				state_d = stat.walk_go ? ST_WALK_EX : ST_WALK_END;
			end
			ST_WALK_EX: begin
				state_d = ST_WALK_RD;
			end
			ST_WALK_END: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_SCAN:     cmd.scan = 1'b1;
			ST_DECIDE:   cmd.decide = 1'b1;
			ST_WALK_RD:  cmd.walk_rd = 1'b1;
			ST_WALK_EX:  cmd.walk_ex = 1'b1;
			ST_WALK_END: cmd.walk_end = 1'b1;
			default:     busy = 1'b1;
		endcase
	end

endmodule

// ----- rtl/epobm_dp.sv -----
// ----------------------------------------------------------------------------
// epobm_dp
// level table, resting order memory, scan compare, fill arithmetic, results
// ----------------------------------------------------------------------------
module epobm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  epobm_pkg::ctl_cmd_t                 cmd,
	output epobm_pkg::dp_stat_t                 stat,
	input  logic                                side,
	input  logic [epobm_pkg::IDENT_W-1:0]       order_ident,
	input  logic [epobm_pkg::QTY_W-1:0]         quantity,
	input  logic [epobm_pkg::PRICE_W-1:0]       price_ticks,
	output logic                                done,
	output logic [epobm_pkg::OUTCOME_W-1:0]     outcome,
	output logic [epobm_pkg::QTY_W-1:0]         filled_qty,
	output logic [epobm_pkg::QTY_W-1:0]         rested_qty,
	output logic [epobm_pkg::AFTER_W-1:0]       level_total_after,
	output logic [epobm_pkg::REMOVED_W-1:0]     orders_removed
);
	import epobm_pkg::*;

	// request latched at accept
	logic               side_q;
	logic [IDENT_W-1:0] ident_q;
	logic [QTY_W-1:0]   qty_q;
	logic [PRICE_W-1:0] price_q;

	logic [NUM_LEVELS-1:0] valid_q;
	logic [NUM_LEVELS-1:0] valid_nx;
	lvl_word_t lvl_mem [NUM_LEVELS];
	ord_word_t ord_mem [NUM_LEVELS*ORDERS_PER_LEVEL];

	// scan
	logic [SLOT_W:0]   scan_addr_q;
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_slot_s1;
	lvl_word_t         opp_rd_s1, own_rd_s1;
	logic              opp_side;
	logic              issue;

	logic              opp_hit_q, own_hit_q, free_hit_q;
	logic [SLOT_W-1:0] opp_slot_q, own_slot_q, free_slot_q;
	lvl_word_t         opp_w_q, own_w_q;

	// walk
	logic [QTY_W-1:0]  rem_q;
	logic [POS_W-1:0]  head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  removed_q;
	ord_word_t         ord_rd_q;

	decision_t         dec;
	logic              own_ok;
	logic [LVL_W-1:0]  opp_idx, own_idx;
	logic [QTY_W-1:0]  put_qty;
	logic [TOT_W-1:0]  put_tot;
	logic [POS_W-1:0]  put_pos;
	logic              do_put;
	lvl_word_t         put_word;
	logic [TOT_W-1:0]  walk_tot;
	logic              ord_fits;

	logic              lvl_we;
	logic [LVL_W-1:0]  lvl_waddr;
	lvl_word_t         lvl_wdata;
	logic              ord_we;
	logic [ORD_ADDR_W-1:0] ord_waddr;
	ord_word_t         ord_wdata;

	assign opp_side = (side_q == BUY) ? SELL : BUY;
	assign issue    = cmd.scan && !scan_addr_q[SLOT_W];
	assign opp_idx  = {opp_side, opp_slot_q};
	assign own_idx  = own_hit_q ? {side_q, own_slot_q} : {side_q, free_slot_q};

	assign own_ok = own_hit_q ? (own_w_q.count < CNT_W'(ORDERS_PER_LEVEL)) : free_hit_q;

	always_comb begin
		if (opp_hit_q) begin
			if (TOT_W'(qty_q) == opp_w_q.total)      dec = DEC_CLEAR;
			else if (TOT_W'(qty_q) < opp_w_q.total)  dec = DEC_WALK;
			else if (own_ok)                         dec = DEC_SWEEP;
			else                                     dec = DEC_REJECT;
		end else begin
			dec = own_ok ? DEC_REST : DEC_REJECT;
		end
	end

	// remainder rests on own side, fresh level when none at that price
	assign put_qty  = (dec == DEC_SWEEP) ? (qty_q - opp_w_q.total[QTY_W-1:0]) : qty_q;
	assign put_tot  = own_hit_q ? (own_w_q.total + TOT_W'(put_qty)) : TOT_W'(put_qty);
	assign put_pos  = own_hit_q ? (own_w_q.head + own_w_q.count[POS_W-1:0]) : '0;
	assign do_put   = cmd.decide && ((dec == DEC_SWEEP) || (dec == DEC_REST));
	always_comb begin
		put_word.price = price_q;
		put_word.total = put_tot;
		put_word.head  = own_hit_q ? own_w_q.head : '0;
		put_word.count = own_hit_q ? (own_w_q.count + CNT_W'(1)) : CNT_W'(1);
	end

	// level valid bits after the decision: opposite cleared on a clear or sweep, own set when the order rests
	always_comb begin
		valid_nx = valid_q;
		if (dec == DEC_CLEAR || dec == DEC_SWEEP) valid_nx[opp_idx] = 1'b0;
		if (do_put) valid_nx[own_idx] = 1'b1;
	end

	assign walk_tot = opp_w_q.total - TOT_W'(qty_q);
	assign ord_fits = ord_rd_q.qty <= rem_q;

	assign stat.scan_done = cmp_vld_s1 && (cmp_slot_s1 == SLOT_W'(LEVELS_PER_SIDE - 1));
	assign stat.need_walk = dec == DEC_WALK;
	assign stat.walk_go   = (rem_q != '0) && (cnt_q != '0);

	// memory write ports
	always_comb begin
		lvl_we    = do_put || cmd.walk_end;
		lvl_waddr = cmd.walk_end ? opp_idx : own_idx;
		lvl_wdata = put_word;
		if (cmd.walk_end) begin
			lvl_wdata.price = opp_w_q.price;
			lvl_wdata.total = walk_tot;
			lvl_wdata.head  = head_q;
			lvl_wdata.count = cnt_q;
		end
		ord_we    = do_put || (cmd.walk_ex && !ord_fits);
		ord_waddr = cmd.walk_ex ? {opp_idx, head_q} : {own_idx, put_pos};
		ord_wdata.ident = cmd.walk_ex ? ord_rd_q.ident : ident_q;
		ord_wdata.qty   = cmd.walk_ex ? (ord_rd_q.qty - rem_q) : put_qty;
	end

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
		opp_rd_s1 <= lvl_mem[{opp_side, scan_addr_q[SLOT_W-1:0]}];
		own_rd_s1 <= lvl_mem[{side_q, scan_addr_q[SLOT_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
		if (cmd.walk_rd) ord_rd_q <= ord_mem[{opp_idx, head_q}];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			side_q  <= side;
			ident_q <= order_ident;
			qty_q   <= quantity;
			price_q <= price_ticks;
		end
		cmp_slot_s1 <= scan_addr_q[SLOT_W-1:0];
		if (cmd.scan && cmp_vld_s1) begin
			if (valid_q[{opp_side, cmp_slot_s1}] &&
				opp_rd_s1.price[PRICE_BITS-1:0] == price_q[PRICE_BITS-1:0] && !opp_hit_q) begin
				opp_slot_q <= cmp_slot_s1;
				opp_w_q    <= opp_rd_s1;
			end
			if (valid_q[{side_q, cmp_slot_s1}] &&
				own_rd_s1.price[PRICE_BITS-1:0] == price_q[PRICE_BITS-1:0] && !own_hit_q) begin
				own_slot_q <= cmp_slot_s1;
				own_w_q    <= own_rd_s1;
			end
			if (!valid_q[{side_q, cmp_slot_s1}] && !free_hit_q) free_slot_q <= cmp_slot_s1;
		end
		if (cmd.decide) begin
			rem_q     <= qty_q;
			head_q    <= opp_w_q.head;
			cnt_q     <= opp_w_q.count;
			removed_q <= '0;
		end
		if (cmd.walk_ex) begin
			if (ord_fits) begin
				rem_q     <= rem_q - ord_rd_q.qty;
				head_q    <= head_q + POS_W'(1);
				cnt_q     <= cnt_q - CNT_W'(1);
				removed_q <= removed_q + CNT_W'(1);
			end else begin
				rem_q <= '0;
			end
		end
		if (cmd.decide) begin
			case (dec)
				DEC_CLEAR: begin
					outcome           <= OC_CLEAR;
					filled_qty        <= qty_q;
					rested_qty        <= '0;
					level_total_after <= '0;
					orders_removed    <= opp_w_q.count;
				end
				DEC_SWEEP: begin
					outcome           <= OC_SWEPT;
					filled_qty        <= opp_w_q.total[QTY_W-1:0];
					rested_qty        <= put_qty;
					level_total_after <= put_tot[AFTER_W-1:0];
					orders_removed    <= opp_w_q.count;
				end
				DEC_REST: begin
					outcome           <= own_hit_q ? OC_JOINED : OC_NEW;
					filled_qty        <= '0;
					rested_qty        <= put_qty;
					level_total_after <= put_tot[AFTER_W-1:0];
					orders_removed    <= '0;
				end
				default: begin
					outcome           <= OC_REJECT;
					filled_qty        <= '0;
					rested_qty        <= '0;
					level_total_after <= '0;
					orders_removed    <= '0;
				end
			endcase
		end
		if (cmd.walk_end) begin
			outcome           <= OC_PARTIAL;
			filled_qty        <= qty_q;
			rested_qty        <= '0;
			level_total_after <= walk_tot[AFTER_W-1:0];
			orders_removed    <= removed_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			scan_addr_q <= '0;
			cmp_vld_s1  <= 1'b0;
			opp_hit_q   <= 1'b0;
			own_hit_q   <= 1'b0;
			free_hit_q  <= 1'b0;
			done        <= 1'b0;
		end else begin
			done       <= (cmd.decide && dec != DEC_WALK) || cmd.walk_end;
			// issue is low while idle, so the compare stage is empty at scan start
			cmp_vld_s1 <= issue;
			if (issue) scan_addr_q <= scan_addr_q + (SLOT_W+1)'(1);
			if (cmd.load) begin
				scan_addr_q <= '0;
				opp_hit_q   <= 1'b0;
				own_hit_q   <= 1'b0;
				free_hit_q  <= 1'b0;
			end
			if (cmd.scan && cmp_vld_s1) begin
				if (valid_q[{opp_side, cmp_slot_s1}] &&
					opp_rd_s1.price[PRICE_BITS-1:0] == price_q[PRICE_BITS-1:0])
					opp_hit_q <= 1'b1;
				if (valid_q[{side_q, cmp_slot_s1}] &&
					own_rd_s1.price[PRICE_BITS-1:0] == price_q[PRICE_BITS-1:0])
					own_hit_q <= 1'b1;
				if (!valid_q[{side_q, cmp_slot_s1}]) free_hit_q <= 1'b1;
			end
			if (cmd.decide) valid_q <= valid_nx;
		end
	end

endmodule

// ----- rtl/exact_price_order_book_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// exact_price_order_book_matcher_unit
// two-sided limit order book with exact-price matching and per-level fifos
// ----------------------------------------------------------------------------
// usage:
//   a request (side, order_ident, quantity, price_ticks) is taken at a rising
//   edge with start high and busy low. exactly one result follows, shown for
//   one cycle with done high: outcome, filled_qty, rested_qty,
//   level_total_after, orders_removed.
// sequence:
//   the price scan reads the level table through two read ports, one slot
//   per side each cycle. a decision state follows. a partial fill then
//   walks the opposite fifo, a read state and an execute state per touched
//   order (registered order memory read), then a last read and a write-back.
//   busy drops in the cycle done is high, so the next request may be taken
//   at the edge that ends the result cycle.
// reset:
//   arst_n clears all level valid bits (empty books) and the sequencer.
//   there is no clearing pass. the receiver cannot stall results.
// ----------------------------------------------------------------------------
module exact_price_order_book_matcher_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             side,
	input  logic [epobm_pkg::IDENT_W-1:0]    order_ident,
	input  logic [epobm_pkg::QTY_W-1:0]      quantity,
	input  logic [epobm_pkg::PRICE_W-1:0]    price_ticks,
	output logic                             done,
	output logic [epobm_pkg::OUTCOME_W-1:0]  outcome,
	output logic [epobm_pkg::QTY_W-1:0]      filled_qty,
	output logic [epobm_pkg::QTY_W-1:0]      rested_qty,
	output logic [epobm_pkg::AFTER_W-1:0]    level_total_after,
	output logic [epobm_pkg::REMOVED_W-1:0]  orders_removed
);
	import epobm_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	epobm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	epobm_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.side              (side),
		.order_ident       (order_ident),
		.quantity          (quantity),
		.price_ticks       (price_ticks),
		.done              (done),
		.outcome           (outcome),
		.filled_qty        (filled_qty),
		.rested_qty        (rested_qty),
		.level_total_after (level_total_after),
		.orders_removed    (orders_removed)
	);

endmodule

// ----- rtl/epobm_checker.sv -----
// ----------------------------------------------------------------------------
// epobm_checker
// port-level checks of the order book matcher, bound to the top level
// ----------------------------------------------------------------------------
`include "exact_price_order_book_matcher_unit_macros.svh"

module epobm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             side,
	input logic [epobm_pkg::IDENT_W-1:0]    order_ident,
	input logic [epobm_pkg::QTY_W-1:0]      quantity,
	input logic [epobm_pkg::PRICE_W-1:0]    price_ticks,
	input logic                             done,
	input logic [epobm_pkg::OUTCOME_W-1:0]  outcome,
	input logic [epobm_pkg::QTY_W-1:0]      filled_qty,
	input logic [epobm_pkg::QTY_W-1:0]      rested_qty,
	input logic [epobm_pkg::AFTER_W-1:0]    level_total_after,
	input logic [epobm_pkg::REMOVED_W-1:0]  orders_removed
);
	import epobm_pkg::*;

	// accepted request keeps the block busy
	`EPOBM_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	// a result only ends work that was under way
	`EPOBM_ASSERT(a_done_after_busy, clk, arst_n, done |-> $past(busy))
	// one result per request, never two in a row
	`EPOBM_NEVER(a_done_twice, clk, arst_n, done && $past(done))
	// a rejected request reports no fill, rest or removal
	`EPOBM_ASSERT(a_reject_zero, clk, arst_n, (done && outcome == OC_REJECT) |-> (filled_qty == '0 && rested_qty == '0 && level_total_after == '0 && orders_removed == '0))
	// resting without a match never fills
	`EPOBM_ASSERT(a_rest_nofill, clk, arst_n, (done && (outcome == OC_NEW || outcome == OC_JOINED)) |-> (filled_qty == '0 && orders_removed == '0))

endmodule

bind exact_price_order_book_matcher_unit epobm_checker u_epobm_checker (.*);
